// ----- hdl/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared widths, opcodes, term type and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int OP_W      = 2;
  localparam int COEF_W    = 16;
  localparam int EXP_W     = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int MAX_TERMS_DEF = 32;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
  } term_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic finish;
  } spa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic merge_done;
    logic produces;
    logic pending_valid;
    logic out_free;
  } spa_status_t;

endpackage

// ----- hdl/spa_if.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial adder channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface spa_in_if;
  import spa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [COEF_W-1:0] coefficient;
  logic signed [EXP_W-1:0]  exponent;

  modport source (output valid, output opcode, output coefficient, output exponent,
                  input ready);
  modport sink (input valid, input opcode, input coefficient, input exponent,
                output ready);
endinterface

interface spa_out_if;
  import spa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_coefficient;
  logic signed [EXP_W-1:0] sum_exponent;
  logic                    term_valid;
  logic                    last;
  logic                    overflowed;

  modport source (output valid, output sum_coefficient, output sum_exponent,
                  output term_valid, output last, output overflowed, input ready);
  modport sink (input valid, input sum_coefficient, input sum_exponent,
                input term_valid, input last, input overflowed, output ready);
endinterface

// ----- hdl/sparse_polynomial_adder.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial adder
// Sorted-merge addition of two sparse polynomials loaded term by term.
// ----------------------------------------------------------------------------
// A load item (opcode 0 for A, 1 for B) is taken whenever the adder is idle:
// the term is put in sorted place by a parallel compare-and-shift over its
// store, zero coefficients are ignored and loads into a full store are
// dropped and flagged. A compute item (opcode 2) walks both store heads at one
// merge step per cycle while the result sink does not stall, with a single
// step for each matched exponent pair, and then closes out with a final beat.
// Each result beat is held one step in a register so that the last flag is
// known when it leaves; an empty sum gives one beat with term_valid low. No
// input is taken while a compute is in progress.
module sparse_polynomial_adder #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input logic      clk,
  input logic      rst,
  spa_in_if.sink   in_ch,
  spa_out_if.source out_ch
);
  import spa_pkg::*;

  spa_cmd_t    cmd;
  spa_status_t sts;

  spa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.opcode),
    .sts(sts), .cmd(cmd)
  );

  spa_datapath #(.MAX_TERMS(MAX_TERMS)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd),
    .coefficient(in_ch.coefficient), .exponent(in_ch.exponent),
    .sts(sts),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sum_coefficient(out_ch.sum_coefficient), .sum_exponent(out_ch.sum_exponent),
    .term_valid(out_ch.term_valid), .last(out_ch.last),
    .overflowed(out_ch.overflowed)
  );

endmodule

// ----- hdl/spa_store.sv -----
// ----------------------------------------------------------------------------
// Sorted term store
// Register file kept in ascending exponent order; inserts by parallel
// compare-and-shift, pops the head by shifting every entry down one place.
// ----------------------------------------------------------------------------
module spa_store #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           insert,
  input  logic           pop,
  input  spa_pkg::term_t new_term,
  output spa_pkg::term_t head,
  output logic           empty,
  output logic           full
);
  import spa_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);

  term_t          entries [MAX_TERMS];
  logic [CW-1:0]  count;
  logic [MAX_TERMS-1:0] lt;

  assign empty = (count == '0);
  assign full  = (count == CW'(MAX_TERMS));
  assign head  = entries[0];

  // An entry stays put when it is live and sorts below the new term.
  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      lt[k] = (CW'(k) < count) && (entries[k].expo < new_term.expo);
    end
  end

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (insert && !lt[k]) begin
        if (k == 0) begin
          entries[k] <= new_term;
        end else if (lt[(k == 0) ? 0 : k-1]) begin
          entries[k] <= new_term;
        end else begin
          entries[k] <= entries[(k == 0) ? 0 : k-1];
        end
      end else if (pop && (k < MAX_TERMS-1)) begin
        entries[k] <= entries[(k < MAX_TERMS-1) ? k+1 : k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (insert) begin
      count <= count + CW'(1);
    end else if (pop) begin
      count <= count - CW'(1);
    end
  end

endmodule

// ----- hdl/spa_datapath.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial adder datapath
// Two sorted stores, the merge compare and add, a one-term holding register
// that lets the last flag be known, and the result output register.
// ----------------------------------------------------------------------------
module spa_datapath #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spa_pkg::spa_cmd_t                cmd,
  input  logic signed [spa_pkg::COEF_W-1:0] coefficient,
  input  logic signed [spa_pkg::EXP_W-1:0]  exponent,
  output spa_pkg::spa_status_t             sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [spa_pkg::SUM_W-1:0] sum_coefficient,
  output logic signed [spa_pkg::EXP_W-1:0] sum_exponent,
  output logic                             term_valid,
  output logic                             last,
  output logic                             overflowed
);
  import spa_pkg::*;

  term_t a_head, b_head, load_term;
  logic  a_empty, a_full, b_empty, b_full;
  logic  coef_nz, ins_a, ins_b, pop_a, pop_b;
  logic  take_a, take_b, take_both;
  logic  signed [SUM_W-1:0] a_ext, b_ext, pair_sum, step_coef;
  logic  signed [EXP_W-1:0] step_expo;
  logic  produces, out_free, push, push_last;

  logic                    load_dropped;
  logic                    pend_valid;
  logic signed [SUM_W-1:0] pend_coef;
  logic signed [EXP_W-1:0] pend_expo;

  assign coef_nz   = (coefficient != '0);
  assign load_term = '{coef: coefficient, expo: exponent};
  assign ins_a     = cmd.load_a && coef_nz && !a_full;
  assign ins_b     = cmd.load_b && coef_nz && !b_full;

  spa_store #(.MAX_TERMS(MAX_TERMS)) u_store_a (
    .clk(clk), .rst(rst), .insert(ins_a), .pop(pop_a), .new_term(load_term),
    .head(a_head), .empty(a_empty), .full(a_full)
  );

  spa_store #(.MAX_TERMS(MAX_TERMS)) u_store_b (
    .clk(clk), .rst(rst), .insert(ins_b), .pop(pop_b), .new_term(load_term),
    .head(b_head), .empty(b_empty), .full(b_full)
  );

  // Merge decision on the two heads.
  assign take_a    = !a_empty && (b_empty || (a_head.expo < b_head.expo));
  assign take_b    = !b_empty && (a_empty || (b_head.expo < a_head.expo));
  assign take_both = !a_empty && !b_empty && (a_head.expo == b_head.expo);
  assign a_ext     = SUM_W'(a_head.coef);
  assign b_ext     = SUM_W'(b_head.coef);
  assign pair_sum  = a_ext + b_ext;

  always_comb begin
    if (take_a) begin
      step_coef = a_ext;
      step_expo = a_head.expo;
    end else if (take_b) begin
      step_coef = b_ext;
      step_expo = b_head.expo;
    end else begin
      step_coef = pair_sum;
      step_expo = a_head.expo;
    end
  end

  assign produces = take_a || take_b || (take_both && (pair_sum != '0));
  assign pop_a    = cmd.step && (take_a || take_both);
  assign pop_b    = cmd.step && (take_b || take_both);

  assign out_free  = !out_valid || out_ready;
  assign push      = cmd.finish || (cmd.step && produces && pend_valid);
  assign push_last = cmd.finish;

  assign sts.merge_done    = a_empty && b_empty;
  assign sts.produces      = produces;
  assign sts.pending_valid = pend_valid;
  assign sts.out_free      = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_dropped <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if ((cmd.load_a && coef_nz && a_full) || (cmd.load_b && coef_nz && b_full)) begin
        load_dropped <= 1'b1;
      end else if (cmd.finish) begin
        load_dropped <= 1'b0;
      end

      if (cmd.step && produces) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end

      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && produces) begin
      pend_coef <= step_coef;
      pend_expo <= step_expo;
    end
    if (push) begin
      // An empty sum still gives one beat, with zeroed term fields.
      sum_coefficient <= (push_last && !pend_valid) ? '0 : pend_coef;
      sum_exponent    <= (push_last && !pend_valid) ? '0 : pend_expo;
      term_valid      <= push_last ? pend_valid : 1'b1;
      last            <= push_last;
      overflowed      <= load_dropped;
    end
  end

  a_finish_marks_last: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && last)
    else $error("finish did not leave a last beat in the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed while the output register was still held");

  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !sts.merge_done && !cmd.finish)
    else $error("merge step issued with both stores empty");

endmodule

// ----- hdl/spa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial adder controller
// Accepts input items while idle and sequences the merge and its final beat.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spa_pkg::OP_W-1:0]    opcode,
  input  spa_pkg::spa_status_t        sts,
  output spa_pkg::spa_cmd_t           cmd
);
  import spa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MERGE  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_LOAD_A:  cmd.load_a = 1'b1;
            OP_LOAD_B:  cmd.load_b = 1'b1;
            OP_COMPUTE: state_next = S_MERGE;
            default:    ;
          endcase
        end
      end
      S_MERGE: begin
        if (sts.merge_done) begin
          state_next = S_FINISH;
        end else if (!sts.produces || !sts.pending_valid || sts.out_free) begin
          // A step that pushes the held term needs a free output register.
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
